>>> sv/rcbg_pkg.sv
// shared types and constants for the contrast, brightness and gray pixel unit
`default_nettype none
package rcbg_pkg;

    localparam int PIX_W     = 8;
    localparam int CTR_W     = 9;
    localparam int BRI_W     = 10;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = BRI_W;

    // contrast factor 255 + c, brightness gain 256 + b
    localparam int FAC_W = CTR_W + 1;
    localparam int GAIN_W = BRI_W + 1;
    localparam int DIFF_W = PIX_W + 1;
    localparam int PROD1_W = FAC_W + DIFF_W;
    localparam int LIN_W = PROD1_W - 1;
    localparam int PROD2_W = LIN_W + GAIN_W;
    localparam int NUM_W = PROD2_W - 1;

    localparam int FAC_BASE = 255;
    localparam int MID_LEVEL = 128;
    localparam int LIN_BIAS = 128 * 255;
    localparam int GAIN_BASE = 256;
    localparam int CB_DEN = 255 * 256;
    localparam int SAT_LIMIT = 255 * CB_DEN;
    localparam int HALF_DEN = CB_DEN / 2;

    // rounded numerator stays below 2^24, quotient by 256 then by 255
    localparam int RND_W = 24;
    localparam int QX_W = RND_W - 8;
    localparam int RECIP_255 = 257;

    localparam int GRAY_SUM_W = PIX_W + 5;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CONTRAST = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BRIGHT   = 2'd2;

    localparam logic MODE_ADJUST = 1'b0;
    localparam logic MODE_GRAY   = 1'b1;

    typedef struct packed {
        logic en1;
        logic en2;
        logic en3;
        logic en4;
        logic vld1;
        logic vld2;
        logic vld3;
        logic vld4;
    } pipe_ctrl_t;

endpackage
`default_nettype wire

>>> sv/rcbg_ctrl.sv
// pipeline valid bits and per-stage advance enables
`default_nettype none
module rcbg_ctrl
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic               out_ready,
    output rcbg_pkg::pipe_ctrl_t    ctrl
);

    logic vld1_reg, vld2_reg, vld3_reg, vld4_reg;
    logic vld1_next, vld2_next, vld3_next, vld4_next;
    logic en1, en2, en3, en4;

    always_comb
    begin
        en4 = !vld4_reg || out_ready;
        en3 = !vld3_reg || en4;
        en2 = !vld2_reg || en3;
        en1 = !vld1_reg || en2;

        vld1_next = en1 ? in_valid : vld1_reg;
        vld2_next = en2 ? vld1_reg : vld2_reg;
        vld3_next = en3 ? vld2_reg : vld3_reg;
        vld4_next = en4 ? vld3_reg : vld4_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
            vld4_reg <= 1'b0;
        end
        else
        begin
            vld1_reg <= vld1_next;
            vld2_reg <= vld2_next;
            vld3_reg <= vld3_next;
            vld4_reg <= vld4_next;
        end
    end

    always_comb
    begin
        ctrl.en1  = en1;
        ctrl.en2  = en2;
        ctrl.en3  = en3;
        ctrl.en4  = en4;
        ctrl.vld1 = vld1_reg;
        ctrl.vld2 = vld2_reg;
        ctrl.vld3 = vld3_reg;
        ctrl.vld4 = vld4_reg;
    end

endmodule
`default_nettype wire

>>> sv/rcbg_lane.sv
// one colour channel of the contrast and brightness datapath
`default_nettype none
module rcbg_lane
(
    input  wire logic                                clk,
    input  wire rcbg_pkg::pipe_ctrl_t                ctrl,
    input  wire logic [rcbg_pkg::PIX_W-1:0]          level_in,
    input  wire logic signed [rcbg_pkg::CTR_W-1:0]   contrast,
    input  wire logic signed [rcbg_pkg::BRI_W-1:0]   brightness,
    output logic [rcbg_pkg::PIX_W-1:0]               level
);

    logic signed [rcbg_pkg::FAC_W-1:0]   factor;
    logic signed [rcbg_pkg::DIFF_W-1:0]  diff;
    logic signed [rcbg_pkg::PROD1_W-1:0] prod1;
    logic signed [rcbg_pkg::PROD1_W-1:0] lin_sum;
    logic signed [rcbg_pkg::LIN_W-1:0]   lin_reg, lin_next;

    logic signed [rcbg_pkg::GAIN_W-1:0]  gain;
    logic signed [rcbg_pkg::PROD2_W-1:0] prod2;
    logic signed [rcbg_pkg::NUM_W-1:0]   num_reg, num_next;

    logic [rcbg_pkg::RND_W-1:0]          rnd_sum;
    logic [rcbg_pkg::RND_W-1:0]          recip_prod;
    logic [rcbg_pkg::QX_W-1:0]           qx_reg, qx_next;
    logic [rcbg_pkg::PIX_W-1:0]          q0_reg, q0_next;
    logic                                zero_reg, zero_next;
    logic                                sat_reg, sat_next;

    logic [rcbg_pkg::QX_W-1:0]           q0_times;
    logic [rcbg_pkg::QX_W-1:0]           rem;
    logic [rcbg_pkg::PIX_W-1:0]          quot;

    // stage 1: contrast line
    always_comb
    begin
        factor  = $signed({contrast[rcbg_pkg::CTR_W-1], contrast})
                + rcbg_pkg::FAC_W'(rcbg_pkg::FAC_BASE);
        diff    = $signed({1'b0, level_in}) - rcbg_pkg::DIFF_W'(rcbg_pkg::MID_LEVEL);
        prod1   = factor * diff;
        lin_sum = prod1 + rcbg_pkg::PROD1_W'(rcbg_pkg::LIN_BIAS);
        lin_next = $signed(lin_sum[rcbg_pkg::LIN_W-1:0]);
    end

    // stage 2: brightness gain
    always_comb
    begin
        gain     = $signed({brightness[rcbg_pkg::BRI_W-1], brightness})
                 + rcbg_pkg::GAIN_W'(rcbg_pkg::GAIN_BASE);
        prod2    = lin_reg * gain;
        num_next = $signed(prod2[rcbg_pkg::NUM_W-1:0]);
    end

    // stage 3: clamp flags, round, divide by 256 and estimate divide by 255
    always_comb
    begin
        zero_next  = (num_reg <= rcbg_pkg::NUM_W'(0));
        sat_next   = (num_reg >= rcbg_pkg::NUM_W'(rcbg_pkg::SAT_LIMIT));
        rnd_sum    = num_reg[rcbg_pkg::RND_W-1:0]
                   + rcbg_pkg::RND_W'(rcbg_pkg::HALF_DEN);
        qx_next    = rnd_sum[rcbg_pkg::RND_W-1:8];
        recip_prod = {8'h00, qx_next} * rcbg_pkg::RND_W'(rcbg_pkg::RECIP_255);
        q0_next    = recip_prod[rcbg_pkg::RND_W-1:rcbg_pkg::QX_W];
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en1)
        begin
            lin_reg <= lin_next;
        end
        if (ctrl.en2)
        begin
            num_reg <= num_next;
        end
        if (ctrl.en3)
        begin
            qx_reg   <= qx_next;
            q0_reg   <= q0_next;
            zero_reg <= zero_next;
            sat_reg  <= sat_next;
        end
    end

    // estimate is low by at most one
    always_comb
    begin
        q0_times = {q0_reg, 8'h00} - {8'h00, q0_reg};
        rem      = qx_reg - q0_times;
        quot     = (rem >= rcbg_pkg::QX_W'(255)) ? q0_reg + 8'd1 : q0_reg;
        if (zero_reg)
        begin
            level = '0;
        end
        else if (sat_reg)
        begin
            level = '1;
        end
        else
        begin
            level = quot;
        end
    end

endmodule
`default_nettype wire

>>> sv/rcbg_merge.sv
// gray path and output register combining the three lanes
`default_nettype none
module rcbg_merge
(
    input  wire logic                        clk,
    input  wire rcbg_pkg::pipe_ctrl_t        ctrl,
    input  wire logic                        mode,
    input  wire logic [rcbg_pkg::PIX_W-1:0]  red_in,
    input  wire logic [rcbg_pkg::PIX_W-1:0]  green_in,
    input  wire logic [rcbg_pkg::PIX_W-1:0]  blue_in,
    input  wire logic                        end_of_frame_in,
    input  wire logic [rcbg_pkg::PIX_W-1:0]  red_level,
    input  wire logic [rcbg_pkg::PIX_W-1:0]  green_level,
    input  wire logic [rcbg_pkg::PIX_W-1:0]  blue_level,
    output logic [rcbg_pkg::PIX_W-1:0]       red_out,
    output logic [rcbg_pkg::PIX_W-1:0]       green_out,
    output logic [rcbg_pkg::PIX_W-1:0]       blue_out,
    output logic                             end_of_frame_out
);

    logic [rcbg_pkg::GRAY_SUM_W-1:0] gray_sum;
    logic [rcbg_pkg::PIX_W-1:0]      gray1_reg, gray2_reg, gray3_reg;
    logic                            eof1_reg, eof2_reg, eof3_reg;
    logic [rcbg_pkg::PIX_W-1:0]      red_reg, green_reg, blue_reg;
    logic [rcbg_pkg::PIX_W-1:0]      red_next, green_next, blue_next;
    logic                            eof_reg;

    // 11r + 16g + 5b, then divide by 32
    always_comb
    begin
        gray_sum = rcbg_pkg::GRAY_SUM_W'(11) * rcbg_pkg::GRAY_SUM_W'(red_in)
                 + {1'b0, green_in, 4'h0}
                 + rcbg_pkg::GRAY_SUM_W'(5) * rcbg_pkg::GRAY_SUM_W'(blue_in);
    end

    always_comb
    begin
        if (mode == rcbg_pkg::MODE_GRAY)
        begin
            red_next   = gray3_reg;
            green_next = gray3_reg;
            blue_next  = gray3_reg;
        end
        else
        begin
            red_next   = red_level;
            green_next = green_level;
            blue_next  = blue_level;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en1)
        begin
            gray1_reg <= gray_sum[rcbg_pkg::GRAY_SUM_W-1:5];
            eof1_reg  <= end_of_frame_in;
        end
        if (ctrl.en2)
        begin
            gray2_reg <= gray1_reg;
            eof2_reg  <= eof1_reg;
        end
        if (ctrl.en3)
        begin
            gray3_reg <= gray2_reg;
            eof3_reg  <= eof2_reg;
        end
        if (ctrl.en4)
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
            eof_reg   <= eof3_reg;
        end
    end

    assign red_out          = red_reg;
    assign green_out        = green_reg;
    assign blue_out         = blue_reg;
    assign end_of_frame_out = eof_reg;

endmodule
`default_nettype wire

>>> sv/rgb_contrast_brightness_gray_unit.sv
// top level of the contrast, brightness and gray pixel unit
//
//  channel  | handshake              | word
//  ---------+------------------------+------------------------------------------
//  pixel in | in_valid / in_ready    | red_in, green_in, blue_in, end_of_frame_in
//  pixel out| out_valid / out_ready  | red_out, green_out, blue_out, end_of_frame_out
//  config   | cfg_we                 | cfg_index, cfg_data
//
// four register stages: stage 1, stage 2, stage 3, then the output register
// one word per cycle sustained while out_ready is high
// latency set by the two lane multipliers and the divide-by-255 estimate and fix-up
// each stage advances when empty or when the stage after it advances
// a stalled output holds its word while earlier stages keep filling bubbles
// reset clears the valid bits and the config registers (identity mapping)
`default_nettype none
module rgb_contrast_brightness_gray_unit
(
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic [rcbg_pkg::PIX_W-1:0]            red_in,
    input  wire logic [rcbg_pkg::PIX_W-1:0]            green_in,
    input  wire logic [rcbg_pkg::PIX_W-1:0]            blue_in,
    input  wire logic                                  end_of_frame_in,
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic [rcbg_pkg::PIX_W-1:0]                 red_out,
    output logic [rcbg_pkg::PIX_W-1:0]                 green_out,
    output logic [rcbg_pkg::PIX_W-1:0]                 blue_out,
    output logic                                       end_of_frame_out,
    input  wire logic                                  cfg_we,
    input  wire logic [rcbg_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [rcbg_pkg::CFG_W-1:0]            cfg_data
);

    logic                                mode_reg;
    logic signed [rcbg_pkg::CTR_W-1:0]   contrast_reg;
    logic signed [rcbg_pkg::BRI_W-1:0]   bright_reg;
    rcbg_pkg::pipe_ctrl_t                ctrl;
    logic [rcbg_pkg::PIX_W-1:0]          red_level, green_level, blue_level;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= rcbg_pkg::MODE_ADJUST;
            contrast_reg <= '0;
            bright_reg   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                rcbg_pkg::CFG_MODE:
                begin
                    mode_reg <= cfg_data[0];
                end
                rcbg_pkg::CFG_CONTRAST:
                begin
                    contrast_reg <= $signed(cfg_data[rcbg_pkg::CTR_W-1:0]);
                end
                rcbg_pkg::CFG_BRIGHT:
                begin
                    bright_reg <= $signed(cfg_data[rcbg_pkg::BRI_W-1:0]);
                end
                default:
                begin
                end
            endcase
        end
    end

    rcbg_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .out_ready (out_ready),
        .ctrl      (ctrl)
    );

    rcbg_lane u_lane_red
    (
        .clk        (clk),
        .ctrl       (ctrl),
        .level_in   (red_in),
        .contrast   (contrast_reg),
        .brightness (bright_reg),
        .level      (red_level)
    );

    rcbg_lane u_lane_green
    (
        .clk        (clk),
        .ctrl       (ctrl),
        .level_in   (green_in),
        .contrast   (contrast_reg),
        .brightness (bright_reg),
        .level      (green_level)
    );

    rcbg_lane u_lane_blue
    (
        .clk        (clk),
        .ctrl       (ctrl),
        .level_in   (blue_in),
        .contrast   (contrast_reg),
        .brightness (bright_reg),
        .level      (blue_level)
    );

    rcbg_merge u_merge
    (
        .clk              (clk),
        .ctrl             (ctrl),
        .mode             (mode_reg),
        .red_in           (red_in),
        .green_in         (green_in),
        .blue_in          (blue_in),
        .end_of_frame_in  (end_of_frame_in),
        .red_level        (red_level),
        .green_level      (green_level),
        .blue_level       (blue_level),
        .red_out          (red_out),
        .green_out        (green_out),
        .blue_out         (blue_out),
        .end_of_frame_out (end_of_frame_out)
    );

    assign in_ready  = ctrl.en1;
    assign out_valid = ctrl.vld4;

    // back-pressure only when every stage holds a word
    a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (ctrl.vld1 && ctrl.vld2 && ctrl.vld3 && ctrl.vld4))
        else $error("input blocked with a bubble in the pipeline");

    a_gray_equal: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && mode_reg == rcbg_pkg::MODE_GRAY) |->
        (red_out == green_out && green_out == blue_out))
        else $error("gray word with unequal channels");

    // zero gain blanks every channel
    a_zero_gain: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && mode_reg == rcbg_pkg::MODE_ADJUST
         && bright_reg == -rcbg_pkg::BRI_W'(rcbg_pkg::GAIN_BASE)) |->
        (red_out == '0 && green_out == '0 && blue_out == '0))
        else $error("zero brightness gain gave a non-black word");

endmodule
`default_nettype wire
